// File: rtl/core/kmer_anchor_chainer_top_assert.svh
// Assertion macros for the k-mer anchor chainer.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef KMER_ANCHOR_CHAINER_TOP_ASSERT_SVH
`define KMER_ANCHOR_CHAINER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define KAC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("assert failed");
`define KAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assert failed");
`else
`define KAC_ASSERT(lbl, clk, rstn, prop)
`define KAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/core/kac_pkg.sv
// Shared types and constants of the k-mer anchor chainer.
// No dependencies.
`default_nettype none
package kac_pkg;
  localparam int MAX_ANCHORS = 32;
  localparam int POS_BITS = 20;
  localparam int GAP_BITS = 20;
  localparam int SKEW_BITS = 9;
  localparam int IDX_BITS = $clog2(MAX_ANCHORS);
  localparam int CNT_BITS = $clog2(MAX_ANCHORS + 1);
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 20;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAP_LIMIT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SKEW_LIMIT = 2'd1;
  localparam logic [GAP_BITS-1:0] GAP_RESET = 20'd200;
  localparam logic [SKEW_BITS-1:0] SKEW_RESET = 9'd51;

  typedef struct packed {
    logic [POS_BITS-1:0] anchor_pos_a;
    logic [POS_BITS-1:0] anchor_pos_b;
    logic                anchor_forward;
    logic                anchor_final;
  } in_word_t;

  typedef struct packed {
    logic [POS_BITS-1:0] chain_pos_a;
    logic [POS_BITS-1:0] chain_pos_b;
    logic                chain_forward;
    logic                chain_end;
  } out_word_t;

  typedef struct packed {
    logic [POS_BITS-1:0] pos_a;
    logic [POS_BITS-1:0] pos_b;
    logic                fwd;
  } anchor_t;
endpackage
`default_nettype wire

// File: rtl/core/kac_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module kac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/kac_pair.sv
// Pair acceptance test of the greedy chain walk.
// Depends on kac_pkg.
`default_nettype none
module kac_pair (
  input  wire kac_pkg::anchor_t                  cur_i,
  input  wire kac_pkg::anchor_t                  nxt_i,
  input  wire logic [kac_pkg::GAP_BITS-1:0]      gap_limit_i,
  input  wire logic [kac_pkg::SKEW_BITS-1:0]     skew_limit_i,
  output logic                                   b_less_o,
  output logic                                   pair_ok_o
);
  localparam int CW = (kac_pkg::POS_BITS > kac_pkg::GAP_BITS) ?
                      kac_pkg::POS_BITS : kac_pkg::GAP_BITS;
  localparam int PW = kac_pkg::POS_BITS + kac_pkg::SKEW_BITS;

  logic [kac_pkg::POS_BITS-1:0] d1, d2, hi, lo;
  logic [PW-1:0] lhs, rhs;

  always_comb begin
    b_less_o = cur_i.pos_b < nxt_i.pos_b;
    d1 = nxt_i.pos_a - cur_i.pos_a;
    d2 = nxt_i.pos_b - cur_i.pos_b;
    hi = (d1 > d2) ? d1 : d2;
    lo = (d1 > d2) ? d2 : d1;
    lhs = {1'b0, hi - lo, 8'd0};
    rhs = PW'(skew_limit_i) * PW'(hi);
    pair_ok_o = b_less_o && (CW'(d1) < CW'(gap_limit_i)) &&
                (CW'(d2) < CW'(gap_limit_i)) && (lhs < rhs);
  end
endmodule
`default_nettype wire

// File: rtl/core/kmer_anchor_chainer_top.sv
// An anchor is accepted in S_IDLE. A later anchor of the set is placed by insertion:
// S_SHIFT moves each stored anchor with larger pos_a up a slot, then the anchor is written,
// with the input held off. The walk starts in S_CHAIN and S_LDCUR, uses S_CMP per compared entry,
// S_EMIT1 and S_EMIT2 per accepted pair and S_FIN for the closing word, stalled by the one-word output register.
// Reset clears the anchor count and loads gap_limit 200 and skew_limit_q8 51.
// Depends on kac_pkg, kac_ram, kac_pair and kmer_anchor_chainer_top_assert.svh.
`default_nettype none
`include "kmer_anchor_chainer_top_assert.svh"
module kmer_anchor_chainer_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [kac_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [kac_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire kac_pkg::in_word_t                 in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output kac_pkg::out_word_t                     out_data_o
);
  localparam int IW = kac_pkg::IDX_BITS;
  localparam int CW = kac_pkg::CNT_BITS;
  localparam int AW = $bits(kac_pkg::anchor_t);

  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT, S_PLACE, S_CHAIN, S_LDCUR, S_CMP, S_EMIT1, S_EMIT2, S_FIN
  } state_e;

  state_e state_q;
  logic [CW-1:0] count_q, nx_q;
  logic [IW-1:0] j_q;
  logic fin_q, pend_v_q, out_v_q;
  kac_pkg::anchor_t t_q, first_q, cur_q, nxt_q, pend_q, in_anchor, rdata;
  kac_pkg::out_word_t out_q;
  logic [kac_pkg::GAP_BITS-1:0] gap_q;
  logic [kac_pkg::SKEW_BITS-1:0] skew_q;

  logic ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [AW-1:0] ram_wdata, ram_rdata;
  logic in_fire, slot_free, out_load, greater, b_less, pair_ok;
  logic [CW:0] nx_inc, nx_inc2;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire = in_valid_i && in_ready_o;
  assign slot_free = !out_v_q || out_ready_i;
  assign out_load = slot_free &&
                    ((state_q == S_EMIT1) || (state_q == S_EMIT2) || (state_q == S_FIN));
  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;
  assign in_anchor = '{pos_a: in_data_i.anchor_pos_a, pos_b: in_data_i.anchor_pos_b,
                       fwd: in_data_i.anchor_forward};
  assign rdata = kac_pkg::anchor_t'(ram_rdata);
  assign greater = rdata.pos_a > t_q.pos_a;
  assign nx_inc = {1'b0, nx_q} + 1'b1;
  assign nx_inc2 = {1'b0, nx_q} + 2'd2;

  kac_ram #(.WIDTH(AW), .DEPTH(kac_pkg::MAX_ANCHORS)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  kac_pair u_pair (
    .cur_i        (cur_q),
    .nxt_i        (rdata),
    .gap_limit_i  (gap_q),
    .skew_limit_i (skew_q),
    .b_less_o     (b_less),
    .pair_ok_o    (pair_ok)
  );

  always_comb begin
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_waddr = j_q;
    ram_wdata = AW'(t_q);
    ram_raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire && (count_q < CW'(kac_pkg::MAX_ANCHORS))) begin
          if (count_q == '0) begin
            ram_we = 1'b1;
            ram_waddr = '0;
            ram_wdata = AW'(in_anchor);
          end else begin
            ram_re = 1'b1;
            ram_raddr = IW'(count_q - 1'b1);
          end
        end
      end
      S_SHIFT: begin
        ram_we = 1'b1;
        if (greater) begin
          ram_wdata = ram_rdata;
          if (j_q != IW'(1)) begin
            ram_re = 1'b1;
            ram_raddr = j_q - IW'(2);
          end
        end
      end
      S_PLACE: ram_we = 1'b1;
      S_CHAIN: ram_re = 1'b1;
      S_LDCUR: begin
        if ({1'b0, nx_q} < {1'b0, count_q}) begin
          ram_re = 1'b1;
          ram_raddr = nx_q[IW-1:0];
        end
      end
      S_CMP: begin
        if (!pair_ok && (nx_inc < {1'b0, count_q})) begin
          ram_re = 1'b1;
          ram_raddr = nx_inc[IW-1:0];
        end
      end
      S_EMIT2: begin
        if (slot_free && (nx_inc < {1'b0, count_q})) begin
          ram_re = 1'b1;
          ram_raddr = nx_inc[IW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      nx_q <= '0;
      j_q <= '0;
      fin_q <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q <= 1'b0;
      t_q <= '0;
      first_q <= '0;
      cur_q <= '0;
      nxt_q <= '0;
      pend_q <= '0;
      out_q <= '0;
      gap_q <= kac_pkg::GAP_RESET;
      skew_q <= kac_pkg::SKEW_RESET;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == kac_pkg::REG_GAP_LIMIT) begin
          gap_q <= cfg_wdata_i[kac_pkg::GAP_BITS-1:0];
        end else if (cfg_idx_i == kac_pkg::REG_SKEW_LIMIT) begin
          skew_q <= cfg_wdata_i[kac_pkg::SKEW_BITS-1:0];
        end
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            t_q <= in_anchor;
            fin_q <= in_data_i.anchor_final;
            j_q <= count_q[IW-1:0];
            if (count_q < CW'(kac_pkg::MAX_ANCHORS)) begin
              if (count_q == '0) begin
                first_q <= in_anchor;
                count_q <= CW'(1);
                state_q <= in_data_i.anchor_final ? S_CHAIN : S_IDLE;
              end else begin
                state_q <= S_SHIFT;
              end
            end else if (in_data_i.anchor_final) begin
              state_q <= S_CHAIN;
            end
          end
        end
        S_SHIFT: begin
          if (greater) begin
            j_q <= j_q - 1'b1;
            if (j_q == IW'(1)) begin
              state_q <= S_PLACE;
            end
          end else begin
            count_q <= count_q + 1'b1;
            state_q <= fin_q ? S_CHAIN : S_IDLE;
          end
        end
        S_PLACE: begin
          count_q <= count_q + 1'b1;
          state_q <= fin_q ? S_CHAIN : S_IDLE;
        end
        S_CHAIN: begin
          pend_q <= first_q;
          pend_v_q <= 1'b1;
          nx_q <= CW'(1);
          state_q <= S_LDCUR;
        end
        S_LDCUR: begin
          cur_q <= rdata;
          state_q <= ({1'b0, nx_q} < {1'b0, count_q}) ? S_CMP : S_FIN;
        end
        S_CMP: begin
          if (pair_ok) begin
            nxt_q <= rdata;
            state_q <= S_EMIT1;
          end else begin
            if (b_less) begin
              cur_q <= rdata;
            end
            nx_q <= nx_inc[CW-1:0];
            if (!(nx_inc < {1'b0, count_q})) begin
              state_q <= S_FIN;
            end
          end
        end
        S_EMIT1: begin
          if (slot_free) begin
            out_q <= '{chain_pos_a: pend_q.pos_a, chain_pos_b: pend_q.pos_b,
                       chain_forward: pend_q.fwd, chain_end: 1'b0};
            pend_q <= cur_q;
            state_q <= S_EMIT2;
          end
        end
        S_EMIT2: begin
          if (slot_free) begin
            out_q <= '{chain_pos_a: pend_q.pos_a, chain_pos_b: pend_q.pos_b,
                       chain_forward: pend_q.fwd, chain_end: 1'b0};
            pend_q <= nxt_q;
            nx_q <= nx_inc2[CW-1:0];
            state_q <= (nx_inc < {1'b0, count_q}) ? S_LDCUR : S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            out_q <= '{chain_pos_a: pend_q.pos_a, chain_pos_b: pend_q.pos_b,
                       chain_forward: pend_q.fwd, chain_end: 1'b1};
            pend_v_q <= 1'b0;
            count_q <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `KAC_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CW'(kac_pkg::MAX_ANCHORS))
  `KAC_ASSERT(a_shift_j, clk_i, rst_ni, (state_q != S_SHIFT) || (j_q != '0))
  `KAC_ASSERT(a_fin_pend, clk_i, rst_ni, (state_q != S_FIN) || pend_v_q)
  `KAC_ASSERT_NEXT(a_emit_seq, clk_i, rst_ni, (state_q == S_EMIT1) && slot_free,
                   (state_q == S_EMIT2) && out_v_q)
endmodule
`default_nettype wire
